// ===== hw/rtl/erlog_pkg.sv =====
// Shared types, widths and codes for the circular event log with statistics.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erlog_pkg;

  // Log geometry.
  localparam int LOG_DEPTH = 64;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  // Fixed field widths.
  localparam int ACT_W    = 2;
  localparam int TIME_W   = 32;
  localparam int TIER_W   = 2;
  localparam int PROTO_W  = 4;
  localparam int CMD_W    = 8;
  localparam int DUR_W    = 32;
  localparam int RIDX_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int STAT_W   = 32;
  localparam int DETAIL_W = TIER_W + 1 + PROTO_W + CMD_W + DUR_W;

  // Widths for the index compare and the slot arithmetic.
  localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W + 1 : RIDX_W + 1;
  localparam int SUM_W = ((IDX_W > RIDX_W) ? IDX_W : RIDX_W) + 2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Tier codes.
  localparam logic [TIER_W-1:0] TIER_INFO  = 2'd0;
  localparam logic [TIER_W-1:0] TIER_WARN  = 2'd1;
  localparam logic [TIER_W-1:0] TIER_ALARM = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [TIME_W-1:0]  event_time;
    logic [TIER_W-1:0]  tier;
    logic               mode_flag;
    logic [PROTO_W-1:0] protocol_code;
    logic [CMD_W-1:0]   command_byte;
    logic [DUR_W-1:0]   duration;
    logic [RIDX_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [TIME_W-1:0]  out_time;
    logic [TIER_W-1:0]  out_tier;
    logic               out_mode;
    logic [PROTO_W-1:0] out_protocol;
    logic [CMD_W-1:0]   out_command;
    logic [DUR_W-1:0]   out_duration;
    logic [COUNT_W-1:0] stored_count;
    logic [STAT_W-1:0]  tier_total;
    logic [STAT_W-1:0]  first_time;
    logic [STAT_W-1:0]  last_time;
    logic [STAT_W-1:0]  longest_duration;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;  // input transfer this cycle
    logic fill;  // memory read data is valid, load the entry fields
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;   // current input is a read whose index is below the count
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/erlog_in_if.sv =====
// Input channel: valid/ready handshake carrying one log request.
// Depends on erlog_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface erlog_in_if;
  logic                         valid;
  logic                         ready;
  logic [erlog_pkg::ACT_W-1:0]   action;
  logic [erlog_pkg::TIME_W-1:0]  event_time;
  logic [erlog_pkg::TIER_W-1:0]  tier;
  logic                         mode_flag;
  logic [erlog_pkg::PROTO_W-1:0] protocol_code;
  logic [erlog_pkg::CMD_W-1:0]   command_byte;
  logic [erlog_pkg::DUR_W-1:0]   duration;
  logic [erlog_pkg::RIDX_W-1:0]  read_index;

  modport source (
    output valid, action, event_time, tier, mode_flag, protocol_code,
           command_byte, duration, read_index,
    input  ready
  );
  modport sink (
    input  valid, action, event_time, tier, mode_flag, protocol_code,
           command_byte, duration, read_index,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/erlog_out_if.sv =====
// Output channel: valid/ready handshake carrying one log result.
// Depends on erlog_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface erlog_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [erlog_pkg::TIME_W-1:0]  out_time;
  logic [erlog_pkg::TIER_W-1:0]  out_tier;
  logic                         out_mode;
  logic [erlog_pkg::PROTO_W-1:0] out_protocol;
  logic [erlog_pkg::CMD_W-1:0]   out_command;
  logic [erlog_pkg::DUR_W-1:0]   out_duration;
  logic [erlog_pkg::COUNT_W-1:0] stored_count;
  logic [erlog_pkg::STAT_W-1:0]  tier_total;
  logic [erlog_pkg::STAT_W-1:0]  first_time;
  logic [erlog_pkg::STAT_W-1:0]  last_time;
  logic [erlog_pkg::STAT_W-1:0]  longest_duration;

  modport source (
    output valid, found, out_time, out_tier, out_mode, out_protocol, out_command,
           out_duration, stored_count, tier_total, first_time, last_time,
           longest_duration,
    input  ready
  );
  modport sink (
    input  valid, found, out_time, out_tier, out_mode, out_protocol, out_command,
           out_duration, stored_count, tier_total, first_time, last_time,
           longest_duration,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/event_ring_log_with_stats_top.sv =====
// Circular event log with running statistics: top level.
// Add, clear and a read that misses show their result in the cycle after the input transfer;
// a read that hits passes through the registered store read and then the result register.
// Throughput: one item per cycle, except while a result waits or a read hit reads the stores.
// Reset (rst, synchronous): clears head, count and statistics; the entry stores are not cleared.
// Depends on erlog_pkg, erlog_in_if, erlog_out_if, erlog_ctrl and erlog_dp.
`timescale 1ns / 1ps
`default_nettype none

module event_ring_log_with_stats_top (
  input wire logic   clk,
  input wire logic   rst,
  erlog_in_if.sink   in_ch,
  erlog_out_if.source out_ch
);
  import erlog_pkg::*;

  cmd_t    cmd;
  status_t sts;
  item_t   item;
  result_t res;

  assign item.action        = in_ch.action;
  assign item.event_time    = in_ch.event_time;
  assign item.tier          = in_ch.tier;
  assign item.mode_flag     = in_ch.mode_flag;
  assign item.protocol_code = in_ch.protocol_code;
  assign item.command_byte  = in_ch.command_byte;
  assign item.duration      = in_ch.duration;
  assign item.read_index    = in_ch.read_index;

  erlog_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  erlog_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .item (item),
    .sts  (sts),
    .res  (res)
  );

  assign out_ch.found            = res.found;
  assign out_ch.out_time         = res.out_time;
  assign out_ch.out_tier         = res.out_tier;
  assign out_ch.out_mode         = res.out_mode;
  assign out_ch.out_protocol     = res.out_protocol;
  assign out_ch.out_command      = res.out_command;
  assign out_ch.out_duration     = res.out_duration;
  assign out_ch.stored_count     = res.stored_count;
  assign out_ch.tier_total       = res.tier_total;
  assign out_ch.first_time       = res.first_time;
  assign out_ch.last_time        = res.last_time;
  assign out_ch.longest_duration = res.longest_duration;

  // An input transfer never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> (!out_ch.valid || out_ch.ready))
    else $error("input transfer while an undelivered result is held");

  // A read hit presents its result once the registered store read has filled the result register.
  a_hit_timing: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && sts.hit) |=> !out_ch.valid ##1 out_ch.valid)
    else $error("read hit result not presented on time");

  // The count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.stored_count <= COUNT_W'(LOG_DEPTH)))
    else $error("stored count above log depth");

  // A found entry implies the log holds at least one entry.
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.found) |-> (out_ch.stored_count != '0))
    else $error("entry found in an empty log");

endmodule

`default_nettype wire

// ===== hw/rtl/erlog_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module erlog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/erlog_ctrl.sv =====
// Controller for the event log: handshake, read-wait state and result valid.
// Depends on erlog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erlog_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire erlog_pkg::status_t sts,
  output erlog_pkg::cmd_t         cmd
);
  import erlog_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  // A new item may enter in the idle state when the result register is empty or drains now.
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign cmd.take = in_valid && in_ready;
  assign cmd.fill = (state == ST_RD);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (cmd.take) begin
          if (sts.hit) begin
            state_next = ST_RD;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_next     = ST_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/erlog_dp.sv =====
// Datapath for the event log: pointers, statistics, entry stores and result register.
// Depends on erlog_pkg and erlog_ram.
`timescale 1ns / 1ps
`default_nettype none

module erlog_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire erlog_pkg::cmd_t  cmd,
  input  wire erlog_pkg::item_t item,
  output erlog_pkg::status_t    sts,
  output erlog_pkg::result_t    res
);
  import erlog_pkg::*;

  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [STAT_W-1:0] info_total;
  logic [STAT_W-1:0] warn_total;
  logic [STAT_W-1:0] alarm_total;
  logic [STAT_W-1:0] first_seen;
  logic [STAT_W-1:0] last_seen;
  logic [STAT_W-1:0] longest_seen;

  logic [IDX_W-1:0]  head_next;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] info_total_next;
  logic [STAT_W-1:0] warn_total_next;
  logic [STAT_W-1:0] alarm_total_next;
  logic [STAT_W-1:0] first_seen_next;
  logic [STAT_W-1:0] last_seen_next;
  logic [STAT_W-1:0] longest_seen_next;
  logic [STAT_W-1:0] tier_sel;

  logic              is_add;
  logic              is_read;
  logic              is_clear;
  logic              hit;
  logic [SUM_W-1:0]  slot_sum;
  logic [SUM_W-1:0]  slot_wrap;
  logic [IDX_W-1:0]  slot;

  logic [TIME_W-1:0]   wr_time;
  logic [DETAIL_W-1:0] wr_detail;
  logic [TIME_W-1:0]   rd_time;
  logic [DETAIL_W-1:0] rd_detail;

  assign is_add   = (item.action == ACT_ADD);
  assign is_read  = (item.action == ACT_READ);
  assign is_clear = (item.action == ACT_CLEAR);

  assign hit     = is_read && (CMP_W'(item.read_index) < CMP_W'(count));
  assign sts.hit = hit;

  // Slot of the entry read_index places back from the newest one.
  // On a hit the index is below the depth, so one conditional subtract wraps it.
  assign slot_sum  = SUM_W'(head) + SUM_W'(LOG_DEPTH - 1) - SUM_W'(item.read_index);
  assign slot_wrap = (slot_sum >= SUM_W'(LOG_DEPTH)) ? slot_sum - SUM_W'(LOG_DEPTH)
                                                     : slot_sum;
  assign slot      = slot_wrap[IDX_W-1:0];

  assign wr_time   = item.event_time;
  assign wr_detail = {item.tier, item.mode_flag, item.protocol_code,
                      item.command_byte, item.duration};

  always_comb begin
    head_next         = head;
    count_next        = count;
    info_total_next   = info_total;
    warn_total_next   = warn_total;
    alarm_total_next  = alarm_total;
    first_seen_next   = first_seen;
    last_seen_next    = last_seen;
    longest_seen_next = longest_seen;
    if (is_add) begin
      head_next  = (head == IDX_W'(LOG_DEPTH - 1)) ? '0 : head + IDX_W'(1);
      if (count < CNT_W'(LOG_DEPTH)) begin
        count_next = count + CNT_W'(1);
      end
      case (item.tier)
        TIER_INFO:  info_total_next  = info_total + STAT_W'(1);
        TIER_WARN:  warn_total_next  = warn_total + STAT_W'(1);
        TIER_ALARM: alarm_total_next = alarm_total + STAT_W'(1);
        default:    ;
      endcase
      if (first_seen == '0) begin
        first_seen_next = item.event_time;
      end
      last_seen_next = item.event_time;
      if (item.duration > longest_seen) begin
        longest_seen_next = item.duration;
      end
    end else if (is_clear) begin
      head_next         = '0;
      count_next        = '0;
      info_total_next   = '0;
      warn_total_next   = '0;
      alarm_total_next  = '0;
      first_seen_next   = '0;
      last_seen_next    = '0;
      longest_seen_next = '0;
    end

    case (item.tier)
      TIER_INFO:  tier_sel = info_total_next;
      TIER_WARN:  tier_sel = warn_total_next;
      TIER_ALARM: tier_sel = alarm_total_next;
      default:    tier_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      info_total   <= '0;
      warn_total   <= '0;
      alarm_total  <= '0;
      first_seen   <= '0;
      last_seen    <= '0;
      longest_seen <= '0;
    end else if (cmd.take) begin
      head         <= head_next;
      count        <= count_next;
      info_total   <= info_total_next;
      warn_total   <= warn_total_next;
      alarm_total  <= alarm_total_next;
      first_seen   <= first_seen_next;
      last_seen    <= last_seen_next;
      longest_seen <= longest_seen_next;
    end
  end

  // Result register: statistics load on the transfer, entry fields in the cycle after,
  // when the stores return the read data.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res.found            <= hit;
      res.out_time         <= '0;
      res.out_tier         <= '0;
      res.out_mode         <= 1'b0;
      res.out_protocol     <= '0;
      res.out_command      <= '0;
      res.out_duration     <= '0;
      res.stored_count     <= COUNT_W'(count_next);
      res.tier_total       <= tier_sel;
      res.first_time       <= first_seen_next;
      res.last_time        <= last_seen_next;
      res.longest_duration <= longest_seen_next;
    end else if (cmd.fill) begin
      res.out_time     <= rd_time;
      res.out_tier     <= rd_detail[DETAIL_W-1 -: TIER_W];
      res.out_mode     <= rd_detail[DUR_W + CMD_W + PROTO_W];
      res.out_protocol <= rd_detail[DUR_W + CMD_W +: PROTO_W];
      res.out_command  <= rd_detail[DUR_W +: CMD_W];
      res.out_duration <= rd_detail[DUR_W-1:0];
    end
  end

  erlog_ram #(
    .WIDTH (TIME_W),
    .DEPTH (LOG_DEPTH)
  ) u_time_store (
    .clk   (clk),
    .we    (cmd.take && is_add),
    .waddr (head),
    .wdata (wr_time),
    .re    (cmd.take && hit),
    .raddr (slot),
    .rdata (rd_time)
  );

  erlog_ram #(
    .WIDTH (DETAIL_W),
    .DEPTH (LOG_DEPTH)
  ) u_detail_store (
    .clk   (clk),
    .we    (cmd.take && is_add),
    .waddr (head),
    .wdata (wr_detail),
    .re    (cmd.take && hit),
    .raddr (slot),
    .rdata (rd_detail)
  );

endmodule

`default_nettype wire
